// File: rtl/pwesr_pkg.sv
// Shared types, constants and the functions that build the exponential table for the setpoint-ramp PID.
`timescale 1ns / 1ps
`default_nettype none
package pwesr_pkg;

  localparam int ExpTableDepthDefault = 64;

  // Configuration register indexes.
  localparam logic [2:0] RegKp     = 3'd0;
  localparam logic [2:0] RegKi     = 3'd1;
  localparam logic [2:0] RegKd     = 3'd2;
  localparam logic [2:0] RegOutLow = 3'd3;
  localparam logic [2:0] RegOutHi  = 3'd4;
  localparam logic [2:0] RegTarget = 3'd5;
  localparam logic [2:0] RegRate   = 3'd6;
  localparam logic [2:0] RegMode   = 3'd7;

  localparam logic [31:0] OutHighReset = 32'h00FF_0000;
  localparam logic [13:0] IntegralFrac = 14'd9830;

  // Input command codes.
  localparam logic CmdCompute = 1'b0;
  localparam logic CmdRestart = 1'b1;

  // One classified item handed from the front part to the back part.
  typedef struct packed {
    logic        restart;
    logic        active;
    logic [15:0] measurement;
    logic [15:0] elapsed_ms;
  } pwesr_item_t;

  // Base ratio exp(-16/depth) in Q2.30 from a truncated 25-term series.
  function automatic logic [63:0] exp_base(input int depth);
    logic [63:0] s;
    logic [63:0] term;
    logic signed [63:0] b;
    s = (64'd16 << 30) / 64'(depth);
    term = 64'd1 << 30;
    b = $signed(term);
    for (int n = 1; n <= 24; n++) begin
      term = ((term * s) >> 30) / 64'(n);
      if (n % 2 == 1) b = b - $signed(term);
      else b = b + $signed(term);
    end
    if (b < 0) b = '0;
    return b;
  endfunction

  // Table entry k in Q2.30, built by repeated rounded multiplication.
  function automatic logic [31:0] exp_entry(input int depth, input int k);
    logic [63:0] b;
    logic [63:0] e;
    b = exp_base(depth);
    e = 64'd1 << 30;
    for (int i = 1; i <= k; i++) begin
      e = ((e * b) + (64'd1 << 29)) >> 30;
    end
    return e[31:0];
  endfunction

endpackage
`default_nettype wire

// File: rtl/pwesr_front.sv
// Front part: accepts items, classifies them and queues them for the back part.
`timescale 1ns / 1ps
`default_nettype none
module pwesr_front
  import pwesr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_cmd,
  input  wire logic [15:0] in_measurement,
  input  wire logic [15:0] in_elapsed,
  input  wire logic        automatic_on,
  output logic             q_valid,
  input  wire logic        q_ready,
  output pwesr_item_t      q_item
);

  // Two-entry queue.
  pwesr_item_t slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  logic        push;
  logic        pop;

  assign in_ready = (fill != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (fill != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // Classify at entry; the user must keep the mode stable while items are outstanding (not enforced here).
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr].restart     <= (in_cmd == CmdRestart);
      slot[wr_ptr].active      <= (in_cmd == CmdCompute) && automatic_on;
      slot[wr_ptr].measurement <= in_measurement;
      slot[wr_ptr].elapsed_ms  <= in_elapsed;
    end
  end

endmodule
`default_nettype wire

// File: rtl/pwesr_div.sv
// Iterative signed divider, one quotient bit a cycle, truncating toward zero.
`timescale 1ns / 1ps
`default_nettype none
module pwesr_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic signed [39:0] dividend,
  input  wire logic signed [31:0] divisor,
  output logic                    done,
  output logic signed [40:0]      quotient
);

  logic [39:0] rem_q;
  logic [39:0] acc;
  logic [31:0] dvs;
  logic        neg;
  logic [5:0]  cnt;
  logic        busy;
  logic [40:0] trial;

  assign trial = {acc, rem_q[39]} - {9'd0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'd40;
        acc   <= '0;
        rem_q <= dividend[39] ? 40'(-dividend) : dividend;
        dvs   <= divisor[31] ? 32'(-divisor) : divisor;
        neg   <= dividend[39] ^ divisor[31];
      end else if (busy) begin
        if (!trial[40]) begin
          acc   <= trial[39:0];
          rem_q <= {rem_q[38:0], 1'b1};
        end else begin
          acc   <= {acc[38:0], rem_q[39]};
          rem_q <= {rem_q[38:0], 1'b0};
        end
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // One extra bit keeps the magnitude 2^39 positive.
  assign quotient = 41'(neg ? -{1'b0, rem_q} : {1'b0, rem_q});

endmodule
`default_nettype wire

// File: rtl/pwesr_back.sv
// Back part: sequencer with one shared multiplier that carries out each item.
`timescale 1ns / 1ps
`default_nettype none
module pwesr_back
  import pwesr_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = ExpTableDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  pwesr_item_t      q_item,
  input  wire logic [31:0] kp_gain,
  input  wire logic [31:0] ki_gain,
  input  wire logic [31:0] kd_gain,
  input  wire logic [31:0] out_low,
  input  wire logic [31:0] out_high,
  input  wire logic [15:0] target,
  input  wire logic [31:0] ramp_rate,
  input  wire logic [1:0]  mode_bits,
  input  wire logic        mode_restart,
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic             res_computed,
  output logic [31:0]      res_drive,
  output logic [15:0]      res_target
);

  localparam int IdxW = $clog2(EXP_TABLE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE, S_PREP, S_DIV_GO, S_DIV_WAIT, S_BOOST, S_RAMP0, S_RAMP1,
    S_EXP0, S_EXP1, S_EXP2, S_OFF, S_OFF2, S_KI, S_KPD, S_SUM, S_KD,
    S_KPE, S_DRIVE, S_HIM, S_OUT
  } state_t;

  state_t state;

  // Persistent controller state.
  logic               restart_pending;
  logic               boost_phase;
  logic               ramp_on;
  logic signed [15:0] boost_target;
  logic [31:0]        ramp_time_ms;
  logic signed [31:0] integral_sum;
  logic signed [15:0] previous_measurement;

  // Working registers.
  logic signed [15:0] meas;
  logic signed [16:0] d_in;
  logic signed [15:0] ramped;
  logic signed [16:0] err;
  logic signed [43:0] sum;
  logic signed [43:0] drive;
  logic signed [31:0] sum_hi;
  logic [63:0]        xval;
  logic [IdxW-1:0]    idx;
  logic [15:0]        frac;
  logic [31:0]        ev;
  logic [31:0]        e0;
  logic [31:0]        e1;
  logic [47:0]        xd;

  // Shared multiplier, registered product.
  logic signed [33:0] ma;
  logic signed [33:0] mb;
  logic signed [67:0] prod;

  // Exponential table, endpoints included.
  logic [31:0] exp_rom [EXP_TABLE_DEPTH + 1];
  always_comb begin
    for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
      exp_rom[k] = exp_entry(EXP_TABLE_DEPTH, k);
    end
  end

  // Divider for out_high*256/kp.
  logic               div_start;
  logic               div_done;
  logic signed [40:0] div_q;
  pwesr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({out_high, 8'd0}),
    .divisor  (kp_gain),
    .done     (div_done),
    .quotient (div_q)
  );
  assign div_start = (state == S_DIV_GO);

  logic signed [40:0] bt_wide;
  logic signed [15:0] bt_sat;
  logic [32:0]        rt_sum;
  logic signed [16:0] gap;
  logic signed [33:0] tgt_s;

  assign q_ready = (state == S_IDLE) && !res_valid;
  assign bt_wide = 41'(div_q) + 41'(meas);
  assign bt_sat  = (bt_wide > 41'sd32767) ? 16'sh7FFF :
                   (bt_wide < -41'sd32768) ? 16'sh8000 : bt_wide[15:0];
  assign rt_sum  = {1'b0, ramp_time_ms} + {17'd0, q_item.elapsed_ms};
  assign gap     = 17'($signed(target)) - 17'(boost_target);
  assign tgt_s   = 34'($signed(target));
  assign xd      = 48'(xval[35:0]) * 48'(EXP_TABLE_DEPTH);

  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // Multiplier operand selection by step.
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_RAMP0: begin ma = 34'(ramp_rate); mb = 34'(ramp_time_ms); end
      S_EXP2:  begin ma = 34'(e0 - e1); mb = 34'(frac); end
      S_OFF:   begin ma = 34'(gap); mb = 34'(ev); end
      S_KI:    begin ma = 34'($signed(ki_gain)); mb = 34'(ramped) - 34'(meas); end
      S_KPD:   begin ma = 34'($signed(kp_gain)); mb = 34'(d_in); end
      S_KD:    begin ma = 34'($signed(kd_gain)); mb = 34'(d_in); end
      S_KPE:   begin ma = 34'($signed(kp_gain)); mb = 34'(err); end
      S_HIM:   begin ma = 34'($signed(out_high)); mb = 34'(IntegralFrac); end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state                <= S_IDLE;
      res_valid            <= 1'b0;
      restart_pending      <= 1'b1;
      boost_phase          <= 1'b1;
      ramp_on              <= 1'b0;
      boost_target         <= '0;
      ramp_time_ms         <= '0;
      integral_sum         <= '0;
      previous_measurement <= '0;
    end else begin
      if (res_valid && res_ready) res_valid <= 1'b0;
      if (mode_restart) begin
        restart_pending <= 1'b1;
        boost_phase     <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid && !res_valid) begin
            res_computed <= 1'b0;
            res_drive    <= '0;
            res_target   <= '0;
            meas         <= $signed(q_item.measurement);
            if (q_item.restart) begin
              restart_pending <= 1'b1;
              boost_phase     <= 1'b1;
              res_valid       <= 1'b1;
            end else if (!q_item.active) begin
              res_valid <= 1'b1;
            end else begin
              if (restart_pending) begin
                integral_sum         <= '0;
                previous_measurement <= $signed(q_item.measurement);
                restart_pending      <= 1'b0;
              end
              ramp_time_ms <= rt_sum[32] ? 32'hFFFF_FFFF : rt_sum[31:0];
              state        <= S_PREP;
            end
          end
        end
        S_PREP: begin
          d_in <= 17'(meas) - 17'(previous_measurement);
          if (boost_phase && (17'(meas) - 17'(previous_measurement)) <= 0) begin
            state <= (kp_gain == '0) ? S_BOOST : S_DIV_GO;
          end else begin
            if (boost_phase) begin
              boost_phase  <= 1'b0;
              ramp_time_ms <= '0;
            end
            ramped <= $signed(target);
            state  <= S_RAMP0;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: if (div_done) state <= S_BOOST;
        S_BOOST: begin
          if (kp_gain == '0 || bt_sat > $signed(target)) begin
            boost_target <= $signed(target);
            ramped       <= $signed(target);
            ramp_on      <= 1'b0;
          end else begin
            boost_target <= bt_sat;
            ramped       <= bt_sat;
            ramp_on      <= 1'b1;
          end
          state <= S_KI;
        end
        S_RAMP0: state <= (ramp_on && gap > 0) ? S_RAMP1 : S_KI;
        S_RAMP1: begin
          xval  <= prod[63:0];
          state <= S_EXP0;
        end
        S_EXP0: begin
          // Segment index and weight from x*depth/16.
          if (xval[63:36] != '0) begin
            ev    <= '0;
            state <= S_OFF;
          end else begin
            idx   <= IdxW'(xd >> 36);
            frac  <= 16'(xd >> 20);
            state <= S_EXP1;
          end
          e0 <= '0;
          e1 <= '0;
        end
        S_EXP1: begin
          e0    <= exp_rom[idx];
          e1    <= exp_rom[{1'b0, idx} + (IdxW+1)'(1)];
          state <= S_EXP2;
        end
        S_EXP2: begin
          // The table entries are loaded; their difference is weighted by frac here.
          state <= S_OFF2;
          ev    <= e0;
        end
        S_OFF2: begin
          ev    <= e0 - 32'(prod[47:16]);
          state <= S_OFF;
        end
        S_OFF: state <= S_SUM;
        default: ;
      endcase
      // Integral, derivative and output steps.
      unique case (state)
        S_SUM: begin
          if (ramp_on && gap > 0) begin
            ramped <= 16'(tgt_s - ((prod[49:0] + 50'd536870912) >>> 30));
          end
          err   <= 17'(tgt_s - ((ramp_on && gap > 0) ?
                   34'((prod[49:0] + 50'd536870912) >>> 30) : 34'd0)) - 17'(meas);
          state <= S_KI;
        end
        S_KI: begin
          err   <= 17'(ramped) - 17'(meas);
          state <= S_HIM;
        end
        S_HIM: begin
          sum   <= 44'(integral_sum) + 44'(prod >>> 8);
          state <= S_KPD;
        end
        S_KPD: begin
          sum_hi <= 32'(prod >>> 16);
          state  <= S_KD;
        end
        S_KD: begin
          if (!mode_bits[1]) sum <= sum - 44'(prod >>> 8);
          state <= S_KPE;
        end
        S_KPE: begin
          if (sum > 44'(sum_hi)) sum <= 44'(sum_hi);
          else if (sum < 44'($signed(out_low))) sum <= 44'($signed(out_low));
          drive <= -44'(prod >>> 8);
          state <= S_DRIVE;
        end
        S_DRIVE: begin
          integral_sum <= sum[31:0];
          drive <= drive + sum + (mode_bits[1] ? 44'(prod >>> 8) : 44'd0);
          state <= S_OUT;
        end
        S_OUT: begin
          res_computed         <= 1'b1;
          res_target           <= ramped;
          res_drive            <= (drive > 44'($signed(out_high))) ? out_high :
                                  (drive < 44'($signed(out_low))) ? out_low : drive[31:0];
          previous_measurement <= meas;
          res_valid            <= 1'b1;
          state                <= S_IDLE;
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// File: rtl/pid_with_exponential_setpoint_ramp_core.sv
// Top level of the PID controller with boosted start and exponential setpoint ramp.
//
//  channel   direction  payload
//  s_axis    in         tdata: measurement, elapsed_ms; tuser: cmd
//  m_axis    out        tdata: drive_output, ramped_target; tuser: computed
//  cfg       in         cfg_we, cfg_index, cfg_data
//
// A restart or manual item is answered straight from the idle state; a computed
// sample steps through the sequencer, and also waits on the boost divider (one
// quotient bit a cycle) while that runs. A pending result holds the sequencer.
// Reset is synchronous; it restores register defaults and the controller state.
// A two-item queue lets input be taken while the sequencer or output stalls.
`timescale 1ns / 1ps
`default_nettype none
module pid_with_exponential_setpoint_ramp_core
  import pwesr_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = ExpTableDepthDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,  // measurement[15:0], elapsed_ms[31:16]
  input  wire logic        s_axis_tuser,  // cmd
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,  // drive_output[31:0], ramped_target[47:32]
  output logic             m_axis_tuser,  // computed
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] kp_gain, ki_gain, kd_gain, out_low, out_high, ramp_rate;
  logic [15:0] target;
  logic [1:0]  mode_bits;
  logic        mode_restart;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      kp_gain <= '0; ki_gain <= '0; kd_gain <= '0; out_low <= '0;
      out_high <= OutHighReset; target <= '0; ramp_rate <= '0; mode_bits <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegKp:     kp_gain   <= cfg_data;
        RegKi:     ki_gain   <= cfg_data;
        RegKd:     kd_gain   <= cfg_data;
        RegOutLow: out_low   <= cfg_data;
        RegOutHi:  out_high  <= cfg_data;
        RegTarget: target    <= cfg_data[15:0];
        RegRate:   ramp_rate <= cfg_data;
        RegMode:   mode_bits <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign mode_restart = cfg_we && (cfg_index == RegMode) && cfg_data[0] && !mode_bits[0];

  logic        q_valid;
  logic        q_ready;
  pwesr_item_t q_item;

  pwesr_front u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s_axis_tvalid),
    .in_ready       (s_axis_tready),
    .in_cmd         (s_axis_tuser),
    .in_measurement (s_axis_tdata[15:0]),
    .in_elapsed     (s_axis_tdata[31:16]),
    .automatic_on   (mode_bits[0]),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item)
  );

  pwesr_back #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_ready      (q_ready),
    .q_item       (q_item),
    .kp_gain      (kp_gain),
    .ki_gain      (ki_gain),
    .kd_gain      (kd_gain),
    .out_low      (out_low),
    .out_high     (out_high),
    .target       (target),
    .ramp_rate    (ramp_rate),
    .mode_bits    (mode_bits),
    .mode_restart (mode_restart),
    .res_valid    (m_axis_tvalid),
    .res_ready    (m_axis_tready),
    .res_computed (m_axis_tuser),
    .res_drive    (m_axis_tdata[31:0]),
    .res_target   (m_axis_tdata[47:32])
  );

endmodule
`default_nettype wire

// File: tb/sv/pwesr_checker.sv
// Checker for the setpoint-ramp PID core: predicts each result item and compares it.
`timescale 1ns / 1ps
module pwesr_checker
  import pwesr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tuser,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [47:0] m_axis_tdata,
  input  wire logic        m_axis_tuser,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output int               pending,
  output int               failures
);

  typedef struct packed {
    logic        computed;
    logic [31:0] drive;
    logic [15:0] setpoint;
  } drive_item_t;

  localparam int Depth = ExpTableDepthDefault;

  drive_item_t drive_queue[$];
  logic [31:0] exp_tab[0:Depth];

  // Controller registers as last written.
  logic [31:0] kp_r, ki_r, kd_r, lo_r, hi_r, rate_r;
  logic [15:0] tgt_r;
  logic [1:0]  mode_r;

  // Controller state.
  logic        restart_pend, in_boost, ramping;
  logic [31:0] boost_sp, ramp_ms, integ;
  logic [15:0] prev_meas;

  // Build the exponential table from a truncated series for exp(-16/Depth).
  initial begin
    logic [63:0] step, term;
    logic signed [63:0] base;
    step = (64'd16 << 30) / Depth;
    term = 64'd1 << 30;
    base = $signed(term);
    for (int n = 1; n <= 24; n++) begin
      term = ((term * step) >> 30) / n;
      if (n % 2 == 1) base = base - $signed(term);
      else base = base + $signed(term);
    end
    if (base < 0) base = 0;
    exp_tab[0] = 32'h4000_0000;
    for (int k = 1; k <= Depth; k++) begin
      exp_tab[k] = 32'(((64'(exp_tab[k-1]) * base) + (64'd1 << 29)) >> 30);
    end
  end

  // exp(-x) in Q2.30 for x in Q32.32, interpolated between table entries.
  function automatic logic [31:0] decay(input logic [63:0] x);
    logic [63:0] p;
    logic [31:0] idx, d;
    logic [15:0] f;
    if (x >= (64'd16 << 32)) return 32'd0;
    p = (x * Depth) >> 4;
    idx = p[63:32];
    if (idx >= Depth) return 32'd0;
    f = p[31:16];
    d = exp_tab[idx] - exp_tab[idx+1];
    return exp_tab[idx] - 32'((64'(d) * f) >> 16);
  endfunction

  // Advance the controller by one input item and return its result item.
  function automatic drive_item_t control_step(input logic cmd, input logic [15:0] m16,
                                               input logic [15:0] el);
    drive_item_t r;
    longint meas, tgt, kp, ki, kd, lo, hi, d_in, bt, gap, sp, err, sum, sum_hi, drv;
    logic [63:0] acc, off;
    r = '0;
    if (cmd == CmdRestart) begin
      restart_pend = 1'b1;
      in_boost = 1'b1;
      return r;
    end
    if (!mode_r[0]) return r;
    meas = longint'($signed(m16));
    tgt = longint'($signed(tgt_r));
    kp = longint'($signed(kp_r));
    ki = longint'($signed(ki_r));
    kd = longint'($signed(kd_r));
    lo = longint'($signed(lo_r));
    hi = longint'($signed(hi_r));
    if (restart_pend) begin
      integ = 32'd0;
      prev_meas = m16;
      restart_pend = 1'b0;
    end
    acc = 64'(ramp_ms) + 64'(el);
    ramp_ms = (acc > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc[31:0];
    d_in = meas - longint'($signed(prev_meas));
    if (in_boost && d_in <= 0) begin
      // Boost setpoint: hold what the full output would reach, capped at target.
      if (kp == 0) bt = tgt;
      else begin
        bt = (hi * 256) / kp + meas;
        if (bt > 32767) bt = 32767;
        if (bt < -32768) bt = -32768;
      end
      if (kp == 0 || bt > tgt) begin
        boost_sp = 32'(tgt);
        sp = tgt;
        ramping = 1'b0;
      end else begin
        boost_sp = 32'(bt);
        sp = bt;
        ramping = 1'b1;
      end
    end else begin
      gap = tgt - longint'($signed(boost_sp));
      if (in_boost) begin
        in_boost = 1'b0;
        ramp_ms = 32'd0;
      end
      sp = tgt;
      if (ramping && gap > 0) begin
        off = (64'(gap) * decay(64'(rate_r) * 64'(ramp_ms)) + (64'd1 << 29)) >> 30;
        sp = tgt - longint'(off);
      end
    end
    err = sp - meas;
    sum_hi = (hi * 9830) >>> 16;
    sum = longint'($signed(integ)) + ((ki * err) >>> 8);
    if (!mode_r[1]) sum = sum - ((kp * d_in) >>> 8);
    if (sum > sum_hi) sum = sum_hi;
    else if (sum < lo) sum = lo;
    integ = 32'(sum);
    drv = mode_r[1] ? ((kp * err) >>> 8) : 0;
    drv = drv + sum - ((kd * d_in) >>> 8);
    if (drv > hi) drv = hi;
    else if (drv < lo) drv = lo;
    prev_meas = m16;
    r.computed = 1'b1;
    r.drive = 32'(drv);
    r.setpoint = 16'(sp);
    return r;
  endfunction

  assign pending = drive_queue.size();

  // Watch all three channels at each rising edge.
  always @(posedge clk) begin
    drive_item_t want;
    if (rst) begin
      kp_r = 0; ki_r = 0; kd_r = 0; lo_r = 0; hi_r = OutHighReset;
      tgt_r = 0; rate_r = 0; mode_r = 0;
      restart_pend = 1'b1; in_boost = 1'b1; ramping = 1'b0;
      boost_sp = 0; ramp_ms = 0; integ = 0; prev_meas = 0;
      drive_queue.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          RegKp:     kp_r = cfg_data;
          RegKi:     ki_r = cfg_data;
          RegKd:     kd_r = cfg_data;
          RegOutLow: lo_r = cfg_data;
          RegOutHi:  hi_r = cfg_data;
          RegTarget: tgt_r = cfg_data[15:0];
          RegRate:   rate_r = cfg_data;
          RegMode: begin
            if (cfg_data[0] && !mode_r[0]) begin
              restart_pend = 1'b1;
              in_boost = 1'b1;
            end
            mode_r = cfg_data[1:0];
          end
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (drive_queue.size() == 0) begin
          $error("unexpected result item: tuser=%0h tdata=%0h", m_axis_tuser, m_axis_tdata);
          failures++;
        end else begin
          want = drive_queue.pop_front();
          if (m_axis_tuser !== want.computed) begin
            $error("computed: expected %0h, got %0h", want.computed, m_axis_tuser);
            failures++;
          end
          if (m_axis_tdata[31:0] !== want.drive) begin
            $error("drive_output: expected %0h, got %0h", want.drive, m_axis_tdata[31:0]);
            failures++;
          end
          if (m_axis_tdata[47:32] !== want.setpoint) begin
            $error("ramped_target: expected %0h, got %0h", want.setpoint,
                   m_axis_tdata[47:32]);
            failures++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        drive_queue.push_back(control_step(s_axis_tuser, s_axis_tdata[15:0],
                                           s_axis_tdata[31:16]));
      end
    end
  end

  initial failures = 0;

endmodule

// File: tb/sv/tb_pid_with_exponential_setpoint_ramp_core.sv
// Testbench top for the setpoint-ramp PID core: stimulus, stalls and the verdict.
`timescale 1ns / 1ps
module tb_pid_with_exponential_setpoint_ramp_core;
  import pwesr_pkg::*;

  localparam int StallLimit = 5000;

  logic        clk, rst;
  logic        s_axis_tvalid, s_axis_tready, s_axis_tuser;
  logic [31:0] s_axis_tdata;
  logic        m_axis_tvalid, m_axis_tready, m_axis_tuser;
  logic [47:0] m_axis_tdata;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [31:0] cfg_data;
  int          pending, failures;
  int          send_idle, recv_idle, hold_req;
  logic [15:0] walk_meas;

  pid_with_exponential_setpoint_ramp_core uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pwesr_checker chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pending(pending), .failures(failures)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: random back-pressure, or a long hold-off when one is requested.
  initial begin
    int hold_left;
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // Watchdog on cycles in which no item moves on either stream.
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
        quiet = 0;
      else quiet++;
      if (quiet >= StallLimit) begin
        $display("** pid_with_exponential_setpoint_ramp_core: FAILED **");
        $finish;
      end
    end
  end

  // Offer one input item, entered and left at a falling edge.
  task automatic send_item(input logic cmd, input logic [15:0] meas, input logic [15:0] el);
    while ($urandom_range(99) < send_idle) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser = cmd;
    s_axis_tdata = {el, meas};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Let every outstanding result drain, then wait out the block's own latency.
  task automatic settle();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (80) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Load a full register set; clearing the mode first forces a restart edge.
  task automatic configure(input logic [31:0] kp, input logic [31:0] ki,
                           input logic [31:0] kd, input logic [31:0] lo,
                           input logic [31:0] hi, input logic [15:0] tgt,
                           input logic [31:0] rate, input logic [1:0] mode,
                           input bit clear_mode);
    settle();
    write_reg(RegKp, kp);
    write_reg(RegKi, ki);
    write_reg(RegKd, kd);
    write_reg(RegOutLow, lo);
    write_reg(RegOutHi, hi);
    write_reg(RegTarget, tgt);
    write_reg(RegRate, rate);
    if (clear_mode) write_reg(RegMode, 2'b00);
    write_reg(RegMode, mode);
  endtask

  // Pick a register set; some phases take the extremes of every field.
  task automatic random_config(input int phase);
    logic [31:0] kp, ki, kd, lo, hi, rate;
    logic [15:0] tgt;
    kp = $urandom_range(32'h0008_0000, 32'h0000_4000);
    if ($urandom_range(1)) kp = -kp;
    ki = $urandom_range(32'h0000_8000);
    kd = $urandom_range(32'h0004_0000);
    hi = $urandom_range(32'h0100_0000, 32'h0001_0000);
    lo = ($urandom_range(1)) ? 32'd0 : -$urandom_range(32'h0010_0000);
    tgt = 16'($urandom_range(16'h4000, 16'h0100));
    rate = $urandom_range(32'h0400_0000);
    case (phase % 5)
      1: begin
        kp = 32'h8000_0000; ki = 32'h7FFF_FFFF; kd = 32'h8000_0000;
        lo = 32'h8000_0000; hi = 32'h7FFF_FFFF; tgt = 16'h7FFF; rate = 32'hFFFF_FFFF;
      end
      2: begin
        kp = 32'h7FFF_FFFF; ki = 32'h8000_0000; kd = 32'h7FFF_FFFF;
        lo = 32'h7FFF_FFFF; hi = 32'h8000_0000; tgt = 16'h8000; rate = 32'd0;
      end
      3: begin
        kp = 32'd0;
        lo = hi;
      end
      default: ;
    endcase
    configure(kp, ki, kd, lo, hi, tgt, rate, 2'($urandom_range(3)) | 2'b01,
              $urandom_range(3) != 0);
  endtask

  // Mostly measurement walks that fall, sit still or climb, with restarts and noise.
  task automatic random_items(input int count);
    int trend, run_left;
    logic [15:0] meas, el;
    trend = 0;
    run_left = 0;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        trend = $urandom_range(2);
        run_left = $urandom_range(20, 3);
      end
      run_left--;
      case ($urandom_range(19))
        0: el = 16'hFFFF;
        1: el = 16'd0;
        default: el = 16'($urandom_range(200, 1));
      endcase
      if ($urandom_range(24) == 0) begin
        send_item(CmdRestart, 16'($urandom), 16'($urandom));
      end else if ($urandom_range(9) == 0) begin
        meas = 16'($urandom);
        send_item(CmdCompute, meas, el);
      end else begin
        case (trend)
          0: walk_meas = walk_meas - 16'($urandom_range(64));
          1: walk_meas = walk_meas;
          default: walk_meas = walk_meas + 16'($urandom_range(256, 1));
        endcase
        send_item(CmdCompute, walk_meas, el);
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = CmdCompute;
    s_axis_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = RegKp;
    cfg_data = '0;
    send_idle = 29;
    recv_idle = 76;
    hold_req = 0;
    walk_meas = 16'h0000;
    repeat (6) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Manual mode after reset, then a restart command while manual.
    send_item(CmdCompute, 16'h1234, 16'd10);
    send_item(CmdRestart, 16'h7FFF, 16'hFFFF);

    // Zero kp: no boost, setpoint is the target straight away.
    configure(32'd0, 32'h0000_0100, 32'h0000_0200, 32'd0, OutHighReset, 16'h0A00,
              32'h0100_0000, 2'b01, 1'b1);
    send_item(CmdCompute, 16'h0000, 16'd0);
    send_item(CmdCompute, 16'h8000, 16'hFFFF);
    send_item(CmdCompute, 16'h7FFF, 16'd1);

    // Boost then ramp, with proportional on error, and a zero gap target.
    configure(32'h0001_0000, 32'h0000_0400, 32'h0000_1000, 32'hFFFF_0000,
              32'h0010_0000, 16'h1000, 32'h0200_0000, 2'b11, 1'b1);
    send_item(CmdCompute, 16'h0100, 16'd100);
    send_item(CmdCompute, 16'h0100, 16'd100);
    send_item(CmdCompute, 16'h0200, 16'd100);
    send_item(CmdCompute, 16'h0300, 16'd200);
    send_item(CmdCompute, 16'h0200, 16'd400);
    send_item(CmdRestart, 16'h0000, 16'd0);
    send_item(CmdCompute, 16'h0FFF, 16'd5);
    send_item(CmdCompute, 16'h0FF0, 16'd5);
    send_item(CmdCompute, 16'h1100, 16'd5);

    // Crossed limits with a negative kp.
    configure(32'hFFFE_0000, 32'h0000_2000, 32'h0000_0000, 32'h0020_0000,
              32'h0010_0000, 16'hF000, 32'hFFFF_FFFF, 2'b01, 1'b0);
    send_item(CmdCompute, 16'h7FFF, 16'd3);
    send_item(CmdCompute, 16'h8000, 16'd3);
    send_item(CmdCompute, 16'h8000, 16'd0);

    // Random phases under three idling patterns.
    for (int phase = 0; phase < 8; phase++) begin
      random_config(phase);
      if (phase < 3) begin
        send_idle = 29; recv_idle = 76;
      end else if (phase < 6) begin
        send_idle = 76; recv_idle = 29;
      end else begin
        send_idle = 0; recv_idle = 0;
      end
      if (phase == 6) hold_req = 600;
      random_items(155);
    end

    settle();
    if (failures == 0) begin
      $display("** pid_with_exponential_setpoint_ramp_core: PASSED **");
    end else begin
      $display("** pid_with_exponential_setpoint_ramp_core: FAILED **");
    end
    $finish;
  end

endmodule
